// ===== rtl/core/sequenced_message_ring_buffer_macros.svh =====
// assertion macros shared by the sequenced message ring buffer rtl
// depends on nothing; included by the modules that carry assertions
`ifndef SEQUENCED_MESSAGE_RING_BUFFER_MACROS_SVH
`define SEQUENCED_MESSAGE_RING_BUFFER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define SMRB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define SMRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/smrb_pkg.sv =====
// shared types, codes and constants of the sequenced message ring buffer
// depends on nothing; used by every module of the block
`default_nettype none

package smrb_pkg;

   localparam int SLOTS_DEFAULT      = 64;
   localparam int MAX_LEN_DEFAULT    = 8;
   localparam int WORD_WIDTH_DEFAULT = 32;

   // fixed field widths of the transactions
   localparam int SEQ_W    = 21;
   localparam int DATUM_W  = 32;
   localparam int STATUS_W = 3;
   localparam int WAIT_W   = 7;

   // widest slot index and message length over the parameter ranges
   localparam int SLOT_W_MAX = 10;
   localparam int LEN_W_MAX  = 7;

   localparam logic [SEQ_W-1:0] NUMBER_LIMIT = SEQ_W'(2000000);

   // both buffers are powers of two so their pointers wrap on their own
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;
   localparam int OUT_DEPTH   = 2;
   localparam int OUT_AW      = 1;
   localparam int OUT_CW      = 2;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_FETCH  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_WORD_TAKEN = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_COMMITTED  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NUM_LIMIT  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EXACT      = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_OLDEST     = 3'd5;
   localparam logic [STATUS_W-1:0] STATUS_NOT_YET    = 3'd6;
   localparam logic [STATUS_W-1:0] STATUS_GAP        = 3'd7;

   typedef struct packed {
      logic               cmd;
      logic [DATUM_W-1:0] datum;
      logic               datum_present;
      logic               end_of_message;
      logic [SEQ_W-1:0]   seq_request;
   } smrb_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SEQ_W-1:0]    seq_number;
      logic [DATUM_W-1:0]  datum_res;
      logic                datum_present_res;
      logic                last;
      logic [WAIT_W-1:0]   waiting;
   } smrb_rsp_type;

   // one classified transaction, handed from the front to the back
   typedef struct packed {
      logic                  is_fetch;
      logic                  word_present;
      logic                  word_ok;
      logic [DATUM_W-1:0]    word;
      logic [LEN_W_MAX-1:0]  stage_idx;
      logic                  eom;
      logic                  commit_ok;
      logic [LEN_W_MAX-1:0]  length;
      logic [SEQ_W-1:0]      seq;
      logic [SLOT_W_MAX-1:0] slot;
      logic                  hit;
      logic [STATUS_W-1:0]   status;
      logic [WAIT_W-1:0]     waiting;
   } smrb_op_type;

endpackage

`default_nettype wire

// ===== rtl/core/sequenced_message_ring_buffer.sv =====
// Sequenced message ring buffer. Append transactions (cmd 0) build a message
// word by word and commit it, on the end flag, to ring slot number mod SLOTS
// under a rising sequence number; fetch transactions (cmd 1) return a message
// by number, one result per word. The front end takes one transaction per
// cycle while its four-entry queue has room; the back end then works them in
// order: an append word is staged and answered; an end transaction that
// commits copies the staged words into the slot ring one per cycle through its
// single write port and then reports the commit (a refused commit copies
// nothing), and a fetch streams the words one per cycle from the slot ring read
// port while the output buffer has room, or gives one status result when the
// message is empty or not found. Slot occupancy follows from the sequence
// counter, so reset needs no clearing pass over the memories.
// depends on smrb_pkg, smrb_front, smrb_queue and smrb_back
`default_nettype none

module sequenced_message_ring_buffer #(
   parameter int SLOTS      = smrb_pkg::SLOTS_DEFAULT,
   parameter int MAX_LEN    = smrb_pkg::MAX_LEN_DEFAULT,
   parameter int WORD_WIDTH = smrb_pkg::WORD_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire smrb_pkg::smrb_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output smrb_pkg::smrb_rsp_type      rsp_data
);

   logic                  q_push;
   logic                  q_full;
   logic                  q_pop;
   logic                  q_valid;
   smrb_pkg::smrb_op_type q_in;
   smrb_pkg::smrb_op_type q_out;

   smrb_front #(
      .SLOTS   (SLOTS),
      .MAX_LEN (MAX_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   smrb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_data  (q_out)
   );

   smrb_back #(
      .SLOTS      (SLOTS),
      .MAX_LEN    (MAX_LEN),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_data    (q_out),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/core/smrb_front.sv =====
// front end: accepts request transactions, keeps the sequence counter and
// staging length, and classifies each transaction for the back end; uses smrb_pkg
`default_nettype none

module smrb_front #(
   parameter int SLOTS   = smrb_pkg::SLOTS_DEFAULT,
   parameter int MAX_LEN = smrb_pkg::MAX_LEN_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire smrb_pkg::smrb_req_type req_data,
   input  wire logic                   q_full,
   output logic                        q_push,
   output smrb_pkg::smrb_op_type       q_data
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int SEQ_W  = smrb_pkg::SEQ_W;
   localparam int DIFF_W = SEQ_W + 1;

   localparam logic [DIFF_W-1:0] SLOTS_D   = DIFF_W'(SLOTS);
   localparam logic [SLOT_W:0]   SLOTS_X   = (SLOT_W + 1)'(SLOTS);
   localparam logic [SEQ_W-1:0]  SLOTS_S   = SEQ_W'(SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
   localparam logic [LEN_W-1:0]  MAX_LEN_L = LEN_W'(MAX_LEN);

   logic [SEQ_W-1:0]  next_num_ff, next_num_in;
   logic [SLOT_W-1:0] slot_ptr_ff, slot_ptr_in;
   logic [LEN_W-1:0]  stage_len_ff, stage_len_in;

   logic              accept;
   logic              is_fetch;
   logic              word_ok;
   logic [LEN_W-1:0]  len_after;
   logic              commit_ok;
   logic              not_yet;
   logic              exact;
   logic              oldest;
   logic [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0] wait_cnt;
   logic [SLOT_W:0]   ptr_dist;
   logic [SLOT_W:0]   ptr_x;
   logic [SLOT_W:0]   want_x;

   assign req_stall = q_full;

   always_comb begin
      accept    = req_valid && !q_full;
      is_fetch  = (req_data.cmd == smrb_pkg::CMD_FETCH);
      word_ok   = (stage_len_ff < MAX_LEN_L);
      len_after = stage_len_ff + LEN_W'(req_data.datum_present && word_ok);
      commit_ok = (next_num_ff < smrb_pkg::NUMBER_LIMIT);

      // every number below next_num_ff has been committed, so slot contents
      // follow from the distance between the request and the counter
      not_yet  = (req_data.seq_request >= next_num_ff);
      diff     = DIFF_W'(next_num_ff) - DIFF_W'(req_data.seq_request);
      exact    = !not_yet && (diff <= SLOTS_D);
      oldest   = !not_yet && (diff > SLOTS_D);
      wait_cnt = (diff >= SLOTS_D) ? SLOTS_D : diff;

      // slot of the requested number, counted back from the write pointer
      ptr_dist = diff[SLOT_W:0];
      ptr_x    = {1'b0, slot_ptr_ff};
      want_x   = (ptr_x >= ptr_dist) ? (ptr_x - ptr_dist) : (ptr_x + SLOTS_X - ptr_dist);

      q_data              = '0;
      q_data.is_fetch     = is_fetch;
      q_data.word_present = req_data.datum_present;
      q_data.word_ok      = word_ok;
      q_data.word         = req_data.datum;
      q_data.stage_idx    = smrb_pkg::LEN_W_MAX'(stage_len_ff);
      q_data.eom          = req_data.end_of_message;
      q_data.commit_ok    = commit_ok;
      q_data.length       = smrb_pkg::LEN_W_MAX'(len_after);
      if (is_fetch) begin
         q_data.hit     = exact || oldest;
         q_data.waiting = not_yet ? '0 : smrb_pkg::WAIT_W'(wait_cnt);
         if (exact) begin
            q_data.status = smrb_pkg::STATUS_EXACT;
            q_data.seq    = req_data.seq_request;
            q_data.slot   = smrb_pkg::SLOT_W_MAX'(want_x[SLOT_W-1:0]);
         end else if (oldest) begin
            q_data.status = smrb_pkg::STATUS_OLDEST;
            q_data.seq    = next_num_ff - SLOTS_S;
            q_data.slot   = smrb_pkg::SLOT_W_MAX'(slot_ptr_ff);
         end else begin
            q_data.status = not_yet ? smrb_pkg::STATUS_NOT_YET : smrb_pkg::STATUS_GAP;
         end
      end else begin
         q_data.seq  = next_num_ff;
         q_data.slot = smrb_pkg::SLOT_W_MAX'(slot_ptr_ff);
      end

      // an append with neither word nor end flag leaves no trace
      q_push = accept && (is_fetch || req_data.datum_present || req_data.end_of_message);

      next_num_in  = next_num_ff;
      slot_ptr_in  = slot_ptr_ff;
      stage_len_in = stage_len_ff;
      if (accept && !is_fetch) begin
         if (req_data.end_of_message) begin
            stage_len_in = '0;
            if (commit_ok) begin
               next_num_in = next_num_ff + SEQ_W'(1);
               slot_ptr_in = (slot_ptr_ff == LAST_SLOT) ? '0 : slot_ptr_ff + SLOT_W'(1);
            end
         end else begin
            stage_len_in = len_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_num_ff  <= '0;
         slot_ptr_ff  <= '0;
         stage_len_ff <= '0;
      end else begin
         next_num_ff  <= next_num_in;
         slot_ptr_ff  <= slot_ptr_in;
         stage_len_ff <= stage_len_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/smrb_queue.sv =====
// short first-in first-out queue of classified transactions between the
// front and the back end; uses smrb_pkg
`default_nettype none

module smrb_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire smrb_pkg::smrb_op_type push_data,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       out_valid,
   output smrb_pkg::smrb_op_type      out_data
);

   localparam int AW = smrb_pkg::QUEUE_AW;
   localparam int CW = smrb_pkg::QUEUE_CW;

   smrb_pkg::smrb_op_type entries_ff [smrb_pkg::QUEUE_DEPTH];
   logic [AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         count_ff, count_in;

   always_comb begin
      full      = (count_ff == CW'(smrb_pkg::QUEUE_DEPTH));
      out_valid = (count_ff != '0);
      out_data  = entries_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff + AW'(push);
      rd_ptr_in = rd_ptr_ff + AW'(pop);
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/smrb_back.sv =====
// back end: staging store, slot ring, length table and the sequencer that
// writes messages and streams result transactions; uses smrb_pkg and the macros
`default_nettype none
`include "sequenced_message_ring_buffer_macros.svh"

module smrb_back #(
   parameter int SLOTS      = smrb_pkg::SLOTS_DEFAULT,
   parameter int MAX_LEN    = smrb_pkg::MAX_LEN_DEFAULT,
   parameter int WORD_WIDTH = smrb_pkg::WORD_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   output logic                       q_pop,
   input  wire smrb_pkg::smrb_op_type q_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output smrb_pkg::smrb_rsp_type     rsp_data
);

   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int LEN_W    = $clog2(MAX_LEN + 1);
   localparam int STG_AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int SW_DEPTH = SLOTS * MAX_LEN;
   localparam int SW_AW    = $clog2(SW_DEPTH);
   localparam int OUT_AW   = smrb_pkg::OUT_AW;
   localparam int OUT_CW   = smrb_pkg::OUT_CW;
   localparam int DATUM_W  = smrb_pkg::DATUM_W;

   localparam logic [SW_AW-1:0] ML_A = SW_AW'(MAX_LEN);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_WORD   = 3'd1;
   localparam logic [2:0] ST_COPY   = 3'd2;
   localparam logic [2:0] ST_COMMIT = 3'd3;
   localparam logic [2:0] ST_STATUS = 3'd4;
   localparam logic [2:0] ST_STREAM = 3'd5;

   // sequencer
   logic [2:0]            state_ff, state_in;
   smrb_pkg::smrb_op_type op_ff, op_in;
   logic [LEN_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic                  copy_pend_ff, copy_pend_in;
   logic [LEN_W-1:0]      copy_idx_ff, copy_idx_in;
   logic                  word_pend_ff, word_pend_in;
   logic                  pend_last_ff, pend_last_in;

   // memories
   logic [WORD_WIDTH-1:0] stage_mem_ff [MAX_LEN];
   logic [WORD_WIDTH-1:0] stage_rd_ff;
   logic [WORD_WIDTH-1:0] slot_mem_ff [SW_DEPTH];
   logic [WORD_WIDTH-1:0] word_rd_ff;
   logic [LEN_W-1:0]      len_mem_ff [SLOTS];
   logic [LEN_W-1:0]      len_rd_ff;

   logic                  stage_we, stage_re;
   logic [STG_AW-1:0]     stage_waddr, stage_raddr;
   logic                  slot_we, slot_re;
   logic [SW_AW-1:0]      slot_base, slot_waddr, slot_raddr;
   logic                  len_we, len_re;
   logic [SLOT_W-1:0]     len_raddr;

   logic [SLOT_W-1:0]     op_slot;
   logic [LEN_W-1:0]      op_len;

   // output buffer
   smrb_pkg::smrb_rsp_type out_mem_ff [smrb_pkg::OUT_DEPTH];
   logic [OUT_AW-1:0]      out_head_ff, out_head_in;
   logic [OUT_CW-1:0]      out_count_ff, out_count_in;
   logic [OUT_AW-1:0]      out_tail;
   logic                   out_pop;
   logic [OUT_CW:0]        out_fill;
   logic                   space_ok;
   logic                   push;
   smrb_pkg::smrb_rsp_type push_data;

   always_comb begin
      op_slot    = op_ff.slot[SLOT_W-1:0];
      op_len     = op_ff.length[LEN_W-1:0];
      slot_base  = SW_AW'(op_slot) * ML_A;
      slot_waddr = slot_base + SW_AW'(copy_idx_ff);
      slot_raddr = slot_base + SW_AW'(rd_cnt_ff);
      stage_waddr = op_ff.stage_idx[STG_AW-1:0];
      stage_raddr = rd_cnt_ff[STG_AW-1:0];
      len_raddr   = q_data.slot[SLOT_W-1:0];

      rsp_valid = (out_count_ff != '0);
      rsp_data  = out_mem_ff[out_head_ff];
      out_pop   = rsp_valid && !rsp_stall;
      out_tail  = out_head_ff + OUT_AW'(out_count_ff);
      // a word read in flight already owns a place in the output buffer
      out_fill  = (OUT_CW + 1)'(out_count_ff) - (OUT_CW + 1)'(out_pop)
                  + (OUT_CW + 1)'(word_pend_ff);
      space_ok  = (out_fill < (OUT_CW + 1)'(smrb_pkg::OUT_DEPTH));
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rd_cnt_in    = rd_cnt_ff;
      copy_pend_in = 1'b0;
      copy_idx_in  = rd_cnt_ff;
      word_pend_in = 1'b0;
      pend_last_in = pend_last_ff;
      q_pop        = 1'b0;
      stage_we     = 1'b0;
      stage_re     = 1'b0;
      slot_we      = copy_pend_ff;
      slot_re      = 1'b0;
      len_we       = 1'b0;
      len_re       = 1'b0;
      push         = 1'b0;
      push_data    = '0;

      if (word_pend_ff) begin
         push                        = 1'b1;
         push_data.status            = op_ff.status;
         push_data.seq_number        = op_ff.seq;
         push_data.datum_res         = DATUM_W'(word_rd_ff);
         push_data.datum_present_res = 1'b1;
         push_data.last              = pend_last_ff;
         push_data.waiting           = op_ff.waiting;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               op_in     = q_data;
               rd_cnt_in = '0;
               if (q_data.is_fetch) begin
                  if (q_data.hit) begin
                     len_re   = 1'b1;
                     state_in = ST_STREAM;
                  end else begin
                     state_in = ST_STATUS;
                  end
               end else if (q_data.word_present) begin
                  state_in = ST_WORD;
               end else if (q_data.commit_ok) begin
                  state_in = ST_COPY;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_WORD: begin
            if (space_ok) begin
               push             = 1'b1;
               push_data.status = op_ff.word_ok ? smrb_pkg::STATUS_WORD_TAKEN
                                                : smrb_pkg::STATUS_TOO_LONG;
               push_data.last   = !op_ff.eom;
               stage_we         = op_ff.word_ok;
               if (!op_ff.eom) begin
                  state_in = ST_IDLE;
               end else if (op_ff.commit_ok) begin
                  state_in = ST_COPY;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_COPY: begin
            // staging read, then the slot write in the next cycle
            if (rd_cnt_ff < op_len) begin
               stage_re     = 1'b1;
               copy_pend_in = 1'b1;
               rd_cnt_in    = rd_cnt_ff + LEN_W'(1);
            end else if (!copy_pend_ff) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (space_ok) begin
               push             = 1'b1;
               push_data.status = op_ff.commit_ok ? smrb_pkg::STATUS_COMMITTED
                                                  : smrb_pkg::STATUS_NUM_LIMIT;
               push_data.seq_number = op_ff.commit_ok ? op_ff.seq : '0;
               push_data.last   = 1'b1;
               len_we           = op_ff.commit_ok;
               state_in         = ST_IDLE;
            end
         end
         ST_STATUS: begin
            if (space_ok) begin
               push                 = 1'b1;
               push_data.status     = op_ff.status;
               push_data.seq_number = op_ff.seq;
               push_data.last       = 1'b1;
               push_data.waiting    = op_ff.waiting;
               state_in             = ST_IDLE;
            end
         end
         ST_STREAM: begin
            if (len_rd_ff == '0) begin
               // empty message
               if (space_ok) begin
                  push                 = 1'b1;
                  push_data.status     = op_ff.status;
                  push_data.seq_number = op_ff.seq;
                  push_data.last       = 1'b1;
                  push_data.waiting    = op_ff.waiting;
                  state_in             = ST_IDLE;
               end
            end else begin
               if ((rd_cnt_ff < len_rd_ff) && space_ok) begin
                  slot_re      = 1'b1;
                  word_pend_in = 1'b1;
                  pend_last_in = ((rd_cnt_ff + LEN_W'(1)) == len_rd_ff);
                  rd_cnt_in    = rd_cnt_ff + LEN_W'(1);
               end
               if (word_pend_ff && (rd_cnt_ff == len_rd_ff)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_head_in  = out_head_ff + OUT_AW'(out_pop);
      out_count_in = out_count_ff + OUT_CW'(push) - OUT_CW'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (stage_we) begin
         stage_mem_ff[stage_waddr] <= WORD_WIDTH'(op_ff.word);
      end
      if (stage_re) begin
         stage_rd_ff <= stage_mem_ff[stage_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem_ff[slot_waddr] <= stage_rd_ff;
      end
      if (slot_re) begin
         word_rd_ff <= slot_mem_ff[slot_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem_ff[op_slot] <= op_len;
      end
      if (len_re) begin
         len_rd_ff <= len_mem_ff[len_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_mem_ff[out_tail] <= push_data;
      end
      op_ff        <= op_in;
      copy_idx_ff  <= copy_idx_in;
      pend_last_ff <= pend_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_cnt_ff    <= '0;
         copy_pend_ff <= 1'b0;
         word_pend_ff <= 1'b0;
         out_head_ff  <= '0;
         out_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         copy_pend_ff <= copy_pend_in;
         word_pend_ff <= word_pend_in;
         out_head_ff  <= out_head_in;
         out_count_ff <= out_count_in;
      end
   end

   `SMRB_ASSERT_IMPL(a_out_no_overflow, clock, reset, push, (out_count_ff != OUT_CW'(smrb_pkg::OUT_DEPTH)) || out_pop, "result written into a full output buffer")
   `SMRB_ASSERT_IMPL(a_idle_no_read, clock, reset, state_ff == ST_IDLE, !word_pend_ff && !copy_pend_ff, "memory read still in flight at idle")
   `SMRB_ASSERT_IMPL(a_copy_bound, clock, reset, state_ff == ST_COPY, rd_cnt_ff <= op_len, "copy ran past the staged length")
   `SMRB_ASSERT_NEXT(a_pop_starts_work, clock, reset, q_pop, state_ff != ST_IDLE, "queue popped without starting work")

endmodule

`default_nettype wire
